/* src/gradient_edge_width_scanner_defines.svh */
// assertion macros for the gradient edge width scanner checker
// no dependencies; included by the checker file only
`ifndef GRADIENT_EDGE_WIDTH_SCANNER_DEFINES_SVH
`define GRADIENT_EDGE_WIDTH_SCANNER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GEWS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gews check failed");

// next-cycle implication, disabled during reset
`define GEWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gews check failed");

`endif

/* src/gews_pkg.sv */
// shared types and constants of the gradient edge width scanner
// no dependencies; imported by the top level
package gews_pkg;

   localparam int GRAD_W      = 16;
   localparam int COUNT_W     = 24;
   localparam int SUM_W       = 34;
   localparam int MEAN_W      = 16;
   localparam int FRAC_W      = 8;
   // rounded numerator sum * 256 + count / 2 can carry one bit past sum * 256
   localparam int NUM_W       = SUM_W + FRAC_W + 1;
   localparam int STEP_W      = $clog2(NUM_W);
   localparam int RSP_DATA_W  = 80;

   localparam logic [GRAD_W-1:0]  THRESH_RESET = 16'd5;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
   localparam logic [MEAN_W-1:0]  MEAN_MAX     = {MEAN_W{1'b1}};

   // sequencer states
   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_LOAD
   } state_type;

endpackage

/* src/gradient_edge_width_scanner.sv */
// Usage notes for gradient_edge_width_scanner.
// Input stream (req_): one gradient sample per transfer; tuser carries the
// mask bit and the line-start mark, tlast marks the last sample of a volume.
// Result stream (rsp_): one transfer per volume with edge count, width sum
// and mean width in unsigned Q8; tuser is the mean-valid flag.
// Config (csr_): one write channel for the edge threshold, always ready;
// write it only while the block is idle.
// Throughput: samples without tlast are taken one per cycle, back to back,
// while the input is open. A tlast sample starts the mean division, a
// 25-bit compare-subtract unit that retires one quotient bit per cycle,
// a step for each numerator bit; req_tready stays low during it and during
// the load of the output register, which waits until that register is free.
// Stall: the result sits in the output register until taken; samples keep
// flowing meanwhile, and the next volume's result waits in the load step
// with the input closed.
// Reset: clears line tracking, accumulators and the output valid, and sets
// the threshold to 5.
// depends on gews_pkg
module gradient_edge_width_scanner
   import gews_pkg::*;
#(
   parameter int LINE_LEN = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   // config write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [GRAD_W-1:0]        csr_data,
   // sample input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic signed [GRAD_W-1:0] req_tdata,    // [15:0] gradient_sample
   input  logic [1:0]               req_tuser,    // [0] inside_mask, [1] line_start
   input  logic                     req_tlast,    // volume_end
   // result output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata,    // [23:0] edge_count,
                                                   // [57:24] width_sum,
                                                   // [73:58] mean_width_q8, zero pad
   output logic                     rsp_tuser     // mean_valid
);

   localparam int POS_W = $clog2(LINE_LEN + 1);
   localparam int IDX_W = $clog2(LINE_LEN);
   localparam logic [POS_W-1:0] LINE_END = POS_W'(LINE_LEN);
   localparam int PAD_W = RSP_DATA_W - COUNT_W - SUM_W - MEAN_W;

   // sequencer
   state_type state_ff, state_in;
   logic      req_fire, div_start, div_step, out_load, out_free;

   // config
   logic [GRAD_W-1:0] thresh_ff;

   // line tracking
   logic [GRAD_W-1:0] prev_mag_ff, prev_mag_in, curr_mag_ff, curr_mag_in;
   logic [GRAD_W-1:0] peak_ff, peak_in;
   logic              prev_p_ff, prev_p_in, curr_p_ff, curr_p_in;
   logic              valley_p_ff, valley_p_in, bound_p_ff, bound_p_in;
   logic [IDX_W-1:0]  valley_ff, valley_in, bound_ff, bound_in;
   logic [POS_W-1:0]  line_pos_ff, line_pos_in;
   logic [COUNT_W-1:0] edges_ff, edges_in, edges_acc;
   logic [SUM_W-1:0]   widths_ff, widths_in, widths_acc;

   // per-sample helpers
   logic [GRAD_W-1:0] mag;
   logic [POS_W-1:0]  pos_sel, pos;
   logic              wrap, clr_line;
   logic [IDX_W-1:0]  here, bound_eff, width;
   logic              close_go;
   logic [SUM_W:0]    sum_ext;

   // divider
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [COUNT_W-1:0] rem_ff, rem_in, dcount_ff, dcount_in;
   logic [SUM_W-1:0]   dsum_ff, dsum_in;
   logic [MEAN_W-1:0]  quo_ff, quo_in;
   logic               ovf_ff, ovf_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W:0]   trial, trial_diff;
   logic               trial_ge;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MEAN_W-1:0]     mean;

   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and sequencer outputs
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      div_step   = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tlast) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            div_step = 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // sample magnitude and line position
   assign mag      = req_tdata[GRAD_W-1] ? (~req_tdata + 1'b1) : req_tdata;
   assign pos_sel  = req_tuser[1] ? '0 : line_pos_ff;
   assign wrap     = (pos_sel >= LINE_END);
   assign pos      = wrap ? '0 : pos_sel;
   assign clr_line = req_tuser[1] || wrap || !req_tuser[0];
   assign here     = (pos != '0) ? IDX_W'(pos - 1'b1) : '0;

   // edge close condition and its width, only on a full tracking step
   assign close_go  = req_tuser[0] && !clr_line && prev_p_ff && curr_p_ff
                      && valley_p_ff && (mag > curr_mag_ff) && (curr_mag_ff < peak_ff)
                      && (peak_ff >= thresh_ff);
   assign bound_eff = bound_p_ff ? bound_ff : here;
   assign width     = (bound_eff >= valley_ff) ? (bound_eff - valley_ff) : '0;
   assign sum_ext   = {1'b0, widths_ff} + (SUM_W + 1)'(width);

   // accumulators including this sample's counted edge
   assign edges_acc  = (close_go && (edges_ff != COUNT_MAX)) ? edges_ff + 1'b1 : edges_ff;
   assign widths_acc = !close_go ? widths_ff
                                 : (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]);

   // line tracking and accumulators
   always_comb begin
      prev_mag_in = prev_mag_ff;
      prev_p_in   = prev_p_ff;
      curr_mag_in = curr_mag_ff;
      curr_p_in   = curr_p_ff;
      valley_in   = valley_ff;
      valley_p_in = valley_p_ff;
      bound_in    = bound_ff;
      bound_p_in  = bound_p_ff;
      peak_in     = peak_ff;
      line_pos_in = line_pos_ff;
      edges_in    = edges_ff;
      widths_in   = widths_ff;
      if (req_fire) begin
         line_pos_in = pos + 1'b1;
         // counted edge
         edges_in  = edges_acc;
         widths_in = widths_acc;
         if (clr_line) begin
            prev_mag_in = '0;
            prev_p_in   = 1'b0;
            curr_mag_in = '0;
            curr_p_in   = 1'b0;
            valley_in   = '0;
            valley_p_in = 1'b0;
            bound_in    = '0;
            bound_p_in  = 1'b0;
            peak_in     = '0;
         end
         if (req_tuser[0]) begin
            if (!prev_p_in) begin
               prev_mag_in = mag;
               prev_p_in   = 1'b1;
            end else if (!curr_p_in) begin
               curr_mag_in = mag;
               curr_p_in   = 1'b1;
               if (mag > prev_mag_in) begin
                  valley_in   = here;
                  valley_p_in = 1'b1;
               end
            end else begin
               if (!valley_p_ff) begin
                  // first rise of the line
                  if (mag > curr_mag_ff) begin
                     valley_in   = here;
                     valley_p_in = 1'b1;
                     peak_in     = mag;
                  end
               end else if (mag > curr_mag_ff && curr_mag_ff < peak_ff) begin
                  // rising again after a peak closes the edge
                  valley_in  = here;
                  bound_in   = '0;
                  bound_p_in = 1'b0;
                  peak_in    = mag;
               end else begin
                  // flat spot after the peak marks the right boundary
                  if (mag == curr_mag_ff && curr_mag_ff < peak_ff && !bound_p_ff) begin
                     bound_in   = here;
                     bound_p_in = 1'b1;
                  end
                  if (mag > peak_ff) begin
                     peak_in = mag;
                  end
               end
               prev_mag_in = curr_mag_ff;
               curr_mag_in = mag;
            end
         end
         // end of volume clears everything for the next one
         if (req_tlast) begin
            prev_mag_in = '0;
            prev_p_in   = 1'b0;
            curr_mag_in = '0;
            curr_p_in   = 1'b0;
            valley_in   = '0;
            valley_p_in = 1'b0;
            bound_in    = '0;
            bound_p_in  = 1'b0;
            peak_in     = '0;
            line_pos_in = '0;
            edges_in    = '0;
            widths_in   = '0;
         end
      end
   end

   // config and tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_RESET;
         prev_mag_ff <= '0;
         prev_p_ff   <= 1'b0;
         curr_mag_ff <= '0;
         curr_p_ff   <= 1'b0;
         valley_ff   <= '0;
         valley_p_ff <= 1'b0;
         bound_ff    <= '0;
         bound_p_ff  <= 1'b0;
         peak_ff     <= '0;
         line_pos_ff <= '0;
         edges_ff    <= '0;
         widths_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_data;
         end
         prev_mag_ff <= prev_mag_in;
         prev_p_ff   <= prev_p_in;
         curr_mag_ff <= curr_mag_in;
         curr_p_ff   <= curr_p_in;
         valley_ff   <= valley_in;
         valley_p_ff <= valley_p_in;
         bound_ff    <= bound_in;
         bound_p_ff  <= bound_p_in;
         peak_ff     <= peak_in;
         line_pos_ff <= line_pos_in;
         edges_ff    <= edges_in;
         widths_ff   <= widths_in;
      end
   end

   // compare-subtract unit, one quotient bit per cycle
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge   = (trial >= {1'b0, dcount_ff});
   assign trial_diff = trial - {1'b0, dcount_ff};

   // divider operand load and iteration
   always_comb begin
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      ovf_in    = ovf_ff;
      step_in   = step_ff;
      dcount_in = dcount_ff;
      dsum_in   = dsum_ff;
      if (div_start) begin
         // rounded numerator: sum * 256 + count / 2
         dcount_in = edges_acc;
         dsum_in   = widths_acc;
         num_in    = NUM_W'({widths_acc, FRAC_W'(0)}) + NUM_W'(edges_acc >> 1);
         rem_in    = '0;
         quo_in    = '0;
         ovf_in    = 1'b0;
         step_in   = '0;
      end else if (div_step) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         quo_in  = {quo_ff[MEAN_W-2:0], trial_ge};
         ovf_in  = ovf_ff | quo_ff[MEAN_W-1];
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      ovf_ff    <= ovf_in;
      step_ff   <= step_in;
      dcount_ff <= dcount_in;
      dsum_ff   <= dsum_in;
   end

   // result formatting and output register
   assign mean = (dcount_ff == '0) ? '0 : (ovf_ff ? MEAN_MAX : quo_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = (dcount_ff != '0);
         rsp_data_in  = {PAD_W'(0), mean, dsum_ff, dcount_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/gews_checker.sv */
// port-level checks for the gradient edge width scanner, bound to the top
// depends on gradient_edge_width_scanner_defines.svh
`include "gradient_edge_width_scanner_defines.svh"

module gews_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds
   `GEWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // mean flag follows a nonzero edge count
   `GEWS_ASSERT_NOW(a_mean_flag, clock, reset, rsp_tvalid, rsp_tuser == (rsp_tdata[23:0] != 24'd0))

   // no edges means zero width sum and zero mean
   `GEWS_ASSERT_NOW(a_zero_count, clock, reset, rsp_tvalid && (rsp_tdata[23:0] == 24'd0), (rsp_tdata[57:24] == 34'd0) && (rsp_tdata[73:58] == 16'd0))

   // the division keeps the input closed after a last sample
   `GEWS_ASSERT_NEXT(a_div_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule

bind gradient_edge_width_scanner gews_checker u_gews_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
